[sv/col_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// col_pkg: shared constants for the cursor ordered list
// Field widths, request codes and status codes used by the list, its
// channel interfaces and its port checker.
// ----------------------------------------------------------------------------
package col_pkg;

    localparam int unsigned DEPTH_DEF       = 64;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    localparam int unsigned REQ_W      = 3;
    localparam int unsigned IN_VALUE_W = 32;
    localparam int unsigned TOTAL_W    = 7;
    localparam int unsigned STATUS_W   = 2;

    localparam logic [REQ_W-1:0] REQ_START   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ATTACH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOITEM = 2'd2;

endpackage

[sv/col_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// col_if: request and response channels of the cursor ordered list
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface col_req_if;
    logic                            valid;
    logic                            ready;
    logic [col_pkg::REQ_W-1:0]       req_type;
    logic [col_pkg::IN_VALUE_W-1:0]  new_value;

    modport source (output valid, output req_type, output new_value, input ready);
    modport sink   (input valid, input req_type, input new_value, output ready);
endinterface

interface col_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [col_pkg::IN_VALUE_W-1:0]  current_value;
    logic [col_pkg::TOTAL_W-1:0]     item_total;
    logic                            has_item;
    logic [col_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output current_value, output item_total,
                    output has_item, output status, input ready);
    modport sink   (input valid, input current_value, input item_total,
                    input has_item, input status, output ready);
endinterface

[sv/cursor_ordered_list.sv]
`timescale 1ns / 1ps
// Sequence: start, advance, query and rejected words pass the read and out states to
//   the response register; a remove that moves entries passes shift and drain first;
//   an insert or attach passes place, after shift and drain when it moves entries.
// Throughput: one request word at a time; the memory, with one write and one read
//   port, moves one entry per cycle; a stalled response word holds the next request.
// Reset: rst_n clears count, cursor and control; the store is not cleared.
// ----------------------------------------------------------------------------
// cursor_ordered_list: bounded ordered list with a cursor
// Entries sit in one memory; inserts and removes shift entries one per cycle
// under a small sequencer, then the entry under the cursor is read out.
// ----------------------------------------------------------------------------
module cursor_ordered_list #(
    parameter int unsigned DEPTH       = col_pkg::DEPTH_DEF,
    parameter int unsigned VALUE_WIDTH = col_pkg::VALUE_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    col_req_if.sink   req,
    col_rsp_if.source rsp
);
    import col_pkg::*;

    localparam int unsigned ADDR_W    = $clog2(DEPTH);
    localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
    localparam int unsigned VAL_EXT_W = (VALUE_WIDTH > IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;
    localparam int unsigned CNT_EXT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PLACE = 6'b001000,
        S_READ  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic                dir_up_reg, dir_up_next;
    logic                place_reg, place_next;
    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic [ADDR_W-1:0]      pend_addr_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   has_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [IN_VALUE_W-1:0]  out_value_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic                   out_has_reg;
    logic [STATUS_W-1:0]    out_status_reg;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic                   mem_we, mem_re;
    logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;

    logic                   accept;
    logic                   out_load;
    logic                   cur_valid;
    logic                   full;
    logic [CNT_W-1:0]       place_pos;
    logic [VAL_EXT_W-1:0]   in_ext;
    logic [VAL_EXT_W-1:0]   rd_ext;
    logic [CNT_EXT_W-1:0]   cnt_ext;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cur_valid = (cur_reg < cnt_reg);
    assign full      = (cnt_reg == DEPTH_CNT);
    assign in_ext    = VAL_EXT_W'(req.new_value);
    assign rd_ext    = VAL_EXT_W'(rd_data_reg);
    assign cnt_ext   = CNT_EXT_W'(cnt_reg);

    // insert goes before the cursor (front if none); attach goes after it (end if none)
    always_comb
    begin
        if (req.req_type == REQ_INSERT)
            place_pos = cur_valid ? cur_reg : '0;
        else
            place_pos = cur_valid ? cur_reg + 1'b1 : cnt_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        rd_ptr_next    = rd_ptr_reg;
        dir_up_next    = dir_up_reg;
        place_next     = place_reg;
        pend_next      = pend_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = rd_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    place_next  = 1'b0;
                    dir_up_next = 1'b1;
                    state_next  = S_READ;
                    case (req.req_type)
                        REQ_START:
                        begin
                            cur_next = '0;
                        end
                        REQ_ADVANCE:
                        begin
                            if (cur_valid)
                                cur_next = cur_reg + 1'b1;
                            else
                                status_next = ST_NOITEM;
                        end
                        REQ_INSERT, REQ_ATTACH:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                cur_next    = place_pos;
                                cnt_next    = cnt_reg + 1'b1;
                                place_next  = 1'b1;
                                rd_ptr_next = ADDR_W'(cnt_reg - 1'b1);
                                left_next   = cnt_reg - place_pos;
                                state_next  = (cnt_reg == place_pos) ? S_PLACE : S_SHIFT;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!cur_valid)
                                status_next = ST_NOITEM;
                            else
                            begin
                                cnt_next    = cnt_reg - 1'b1;
                                dir_up_next = 1'b0;
                                rd_ptr_next = ADDR_W'(cur_reg + 1'b1);
                                left_next   = cnt_reg - cur_reg - 1'b1;
                                if (cnt_reg - cur_reg != CNT_W'(1))
                                    state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // read one entry ahead, write the one read last cycle
                mem_we      = pend_reg;
                mem_re      = 1'b1;
                pend_next   = 1'b1;
                rd_ptr_next = dir_up_reg ? rd_ptr_reg - 1'b1 : rd_ptr_reg + 1'b1;
                left_next   = left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                mem_we     = 1'b1;
                pend_next  = 1'b0;
                state_next = place_reg ? S_PLACE : S_READ;
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg[ADDR_W-1:0];
                mem_wdata  = value_reg;
                state_next = S_READ;
            end
            S_READ:
            begin
                mem_re     = cur_valid;
                mem_raddr  = cur_reg[ADDR_W-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the response register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            left_reg      <= '0;
            rd_ptr_reg    <= '0;
            dir_up_reg    <= 1'b1;
            place_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            rd_ptr_reg    <= rd_ptr_next;
            dir_up_reg    <= dir_up_next;
            place_reg     <= place_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (accept)
            value_reg <= in_ext[VALUE_WIDTH-1:0];
        if (state_reg == S_SHIFT)
            pend_addr_reg <= dir_up_reg ? rd_ptr_reg + 1'b1 : rd_ptr_reg - 1'b1;
        if (state_reg == S_READ)
            has_reg <= cur_valid;
        if (out_load)
        begin
            out_value_reg  <= has_reg ? rd_ext[IN_VALUE_W-1:0] : '0;
            out_total_reg  <= cnt_ext[TOTAL_W-1:0];
            out_has_reg    <= has_reg;
            out_status_reg <= status_reg;
        end
    end

    // entry store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.current_value = out_value_reg;
    assign rsp.item_total    = out_total_reg;
    assign rsp.has_item      = out_has_reg;
    assign rsp.status        = out_status_reg;

endmodule

[sv/col_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// col_checker: port checks for the cursor ordered list
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module col_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [col_pkg::IN_VALUE_W-1:0] current_value,
    input logic [col_pkg::TOTAL_W-1:0]   item_total,
    input logic                          has_item,
    input logic [col_pkg::STATUS_W-1:0]  status
);
    import col_pkg::*;

    // an empty cursor reports a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !has_item |-> current_value == '0)
        else $error("current_value not zero without a current item");

    // a current item needs a nonempty list
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && has_item |-> item_total != '0)
        else $error("has_item set on an empty list");

    // a stalled response word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(current_value)
            && $stable(item_total) && $stable(has_item) && $stable(status))
        else $error("response word changed while stalled");

    // the list works one request word at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind cursor_ordered_list col_checker u_col_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .current_value (rsp.current_value),
    .item_total    (rsp.item_total),
    .has_item      (rsp.has_item),
    .status        (rsp.status)
);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cursor ordered list
// A short table of requests covers the corner cases, then phases of random
// requests grow, drain and churn the list. Each response word is checked
// against a local list model or its row's pinned view, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import col_pkg::*;

    // request codes outside the defined set; the list treats them as a query
    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

    localparam int unsigned RANDOM_WORDS  = 750;
    localparam int unsigned FIRST_GROW    = 100;
    localparam int unsigned SETTLE_CYCLES = DEPTH_DEF + 16;
    localparam int unsigned HOLD_AT       = 200;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] current_value;
        logic [TOTAL_W-1:0]    item_total;
        logic                  has_item;
        logic [STATUS_W-1:0]   status;
    } list_view_t;

    typedef struct {
        logic [REQ_W-1:0]      req_type;
        logic [IN_VALUE_W-1:0] new_value;
        bit                    pinned;
        list_view_t            view;
    } dir_row_t;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

    logic clk = 1'b0;
    logic rst_n;

    col_req_if req_ch ();
    col_rsp_if rsp_ch ();

    cursor_ordered_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // local copy of the list
    logic [IN_VALUE_W-1:0] list_mem [DEPTH_DEF];
    int unsigned           list_count  = 0;
    int unsigned           list_cursor = 0;

    list_view_t pending_views [$];
    dir_row_t   dir_rows [$];
    int         err_count  = 0;
    int         rsp_count  = 0;
    int         send_calm  = 0;
    int         sink_calm  = 0;

    function automatic list_view_t apply_request(input logic [REQ_W-1:0] kind,
                                                 input logic [IN_VALUE_W-1:0] value);
        list_view_t          view;
        int unsigned         pos;
        logic [STATUS_W-1:0] st;
        st = ST_OK;
        case (kind)
            REQ_START:
                list_cursor = 0;
            REQ_ADVANCE:
                if (list_cursor < list_count)
                    list_cursor++;
                else
                    st = ST_NOITEM;
            REQ_INSERT, REQ_ATTACH:
                if (list_count >= DEPTH_DEF)
                    st = ST_FULL;
                else
                begin
                    if (kind == REQ_INSERT)
                    begin
                        if (list_cursor >= list_count)
                            list_cursor = 0;
                    end
                    else if (list_cursor < list_count)
                        list_cursor++;
                    else
                        list_cursor = list_count;
                    // open a gap at the cursor
                    for (pos = list_count; pos > list_cursor; pos--)
                        list_mem[pos] = list_mem[pos-1];
                    list_mem[list_cursor] = value;
                    list_count++;
                end
            REQ_REMOVE:
                if (list_cursor >= list_count)
                    st = ST_NOITEM;
                else
                begin
                    for (pos = list_cursor; pos + 1 < list_count; pos++)
                        list_mem[pos] = list_mem[pos+1];
                    list_count--;
                end
            default:
                ;
        endcase
        if (list_cursor < list_count)
        begin
            view.current_value = list_mem[list_cursor];
            view.has_item      = 1'b1;
        end
        else
        begin
            view.current_value = '0;
            view.has_item      = 1'b0;
        end
        view.item_total = list_count[TOTAL_W-1:0];
        view.status     = st;
        return view;
    endfunction

    // wait before the next word; now and then run a stretch with no waits
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [REQ_W-1:0] pick_kind(input phase_t phase);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_GROW:
                if (roll < 40)      return REQ_INSERT;
                else if (roll < 75) return REQ_ATTACH;
                else if (roll < 85) return REQ_ADVANCE;
                else if (roll < 92) return REQ_START;
                else if (roll < 96) return REQ_REMOVE;
                else                return REQ_QUERY;
            PH_SHRINK:
                if (roll < 55)      return REQ_REMOVE;
                else if (roll < 70) return REQ_ADVANCE;
                else if (roll < 82) return REQ_START;
                else if (roll < 90) return REQ_INSERT;
                else if (roll < 95) return REQ_ATTACH;
                else                return REQ_QUERY;
            default:
                return REQ_W'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [IN_VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return IN_VALUE_W'($urandom_range(0, 15));
            default: return IN_VALUE_W'($urandom);
        endcase
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] kind, input logic [IN_VALUE_W-1:0] value,
                           input bit pinned, input logic [IN_VALUE_W-1:0] cur,
                           input logic [TOTAL_W-1:0] total, input logic has,
                           input logic [STATUS_W-1:0] st);
        dir_row_t row;
        row.req_type           = kind;
        row.new_value          = value;
        row.pinned             = pinned;
        row.view.current_value = cur;
        row.view.item_total    = total;
        row.view.has_item      = has;
        row.view.status        = st;
        dir_rows.push_back(row);
    endtask

    // offer one word from a falling edge; return at the falling edge after it moves
    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [IN_VALUE_W-1:0] value,
                             input bit pinned, input list_view_t pinned_view);
        int         gap;
        list_view_t predicted;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.new_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_request(kind, value);
        pending_views.push_back(pinned ? pinned_view : predicted);
        @(negedge clk);
    endtask

    initial
    begin : req_side
        phase_t      phase;
        int unsigned chunk;
        int unsigned sent;
        int unsigned i;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_QUERY;
        req_ch.new_value = '0;
        rst_n            = 1'b0;

        add_row(REQ_QUERY,   '0,            1'b1, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_ADVANCE, '0,            1'b1, '0,            7'd0, 1'b0, ST_NOITEM);
        add_row(REQ_REMOVE,  '0,            1'b1, '0,            7'd0, 1'b0, ST_NOITEM);
        add_row(REQ_SPARE6,  '1,            1'b1, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_SPARE7,  '0,            1'b1, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_INSERT,  '1,            1'b1, '1,            7'd1, 1'b1, ST_OK);
        add_row(REQ_ATTACH,  '0,            1'b1, '0,            7'd2, 1'b1, ST_OK);
        add_row(REQ_INSERT,  32'h5A5A_5A5A, 1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_START,   '0,            1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_ADVANCE, '0,            1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_ATTACH,  32'hA5A5_A5A5, 1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_REMOVE,  '0,            1'b0, '0,            7'd0, 1'b0, ST_OK);
        // removing the tail leaves the cursor past the end
        add_row(REQ_REMOVE,  '0,            1'b1, '0,            7'd2, 1'b0, ST_OK);
        add_row(REQ_ADVANCE, '0,            1'b1, '0,            7'd2, 1'b0, ST_NOITEM);
        add_row(REQ_ATTACH,  32'h1234_5678, 1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_ADVANCE, '0,            1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_INSERT,  32'h0000_FFFF, 1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_QUERY,   '0,            1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_REMOVE,  '0,            1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_REMOVE,  '0,            1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_REMOVE,  '0,            1'b0, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_REMOVE,  '0,            1'b1, '0,            7'd0, 1'b0, ST_OK);
        add_row(REQ_REMOVE,  '0,            1'b1, '0,            7'd0, 1'b0, ST_NOITEM);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
            send_word(dir_rows[k].req_type, dir_rows[k].new_value,
                      dir_rows[k].pinned, dir_rows[k].view);

        // open with a long growth phase so the store fills and rejects
        sent  = 0;
        phase = PH_GROW;
        chunk = FIRST_GROW;
        while (sent < RANDOM_WORDS)
        begin
            for (i = 0; i < chunk && sent < RANDOM_WORDS; i++)
            begin
                send_word(pick_kind(phase), pick_value(), 1'b0, '0);
                sent++;
            end
            phase = phase_t'($urandom_range(0, 2));
            chunk = $urandom_range(20, 80);
        end
        req_ch.valid <= 1'b0;

        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_views.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : rsp_side
        int         gap;
        list_view_t got;
        list_view_t want;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            // hold off once for a long stretch so the request side backs up
            if (rsp_count == HOLD_AT)
                gap = HOLD_CYCLES;
            else
                gap = draw_gap(sink_calm);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            got.current_value = rsp_ch.current_value;
            got.item_total    = rsp_ch.item_total;
            got.has_item      = rsp_ch.has_item;
            got.status        = rsp_ch.status;
            rsp_count++;
            if (pending_views.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("%0t: response word with none pending: value %h total %0d has %0b status %0d",
                             $realtime, got.current_value, got.item_total, got.has_item,
                             got.status);
            end
            else
            begin
                want = pending_views.pop_front();
                if (got.current_value !== want.current_value || got.item_total !== want.item_total
                    || got.has_item !== want.has_item || got.status !== want.status)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("%0t: response %0d mismatch: value %h/%h total %0d/%0d has %0b/%0b status %0d/%0d (expected/actual)",
                                 $realtime, rsp_count, want.current_value, got.current_value,
                                 want.item_total, got.item_total, want.has_item, got.has_item,
                                 want.status, got.status);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
